FILE: design/terminal_escape_key_decoder_defines.svh
// ----------------------------------------------------------------------------
// terminal escape key decoder: assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef TERMINAL_ESCAPE_KEY_DECODER_DEFINES_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define TEKD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TEKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TEKD_ASSERT_SAME(lbl, ante, cons, msg)
`define TEKD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// shared types, byte codes and key table for the escape key decoder
// ----------------------------------------------------------------------------
package tekd_pkg;

  localparam int unsigned TEKD_MAX_SEQ_BYTES = 9;
  localparam int unsigned SEQ_W = 4;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;
  localparam logic [7:0] BYTE_SS3   = 8'h4F;
  localparam logic [7:0] BYTE_A     = 8'h41;
  localparam logic [7:0] BYTE_D     = 8'h44;
  localparam logic [7:0] BYTE_P     = 8'h50;
  localparam logic [7:0] BYTE_S     = 8'h53;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_RAW  = 2'd2;

  localparam logic [4:0] KEY_NONE  = 5'd0;
  localparam logic [4:0] KEY_UP    = 5'd1;
  localparam logic [4:0] KEY_HOME  = 5'd5;
  localparam logic [4:0] KEY_INS   = 5'd6;
  localparam logic [4:0] KEY_DEL   = 5'd7;
  localparam logic [4:0] KEY_END   = 5'd8;
  localparam logic [4:0] KEY_PGUP  = 5'd9;
  localparam logic [4:0] KEY_PGDN  = 5'd10;
  localparam logic [4:0] KEY_F1    = 5'd11;
  localparam logic [4:0] KEY_F5    = 5'd15;
  localparam logic [4:0] KEY_F6    = 5'd16;
  localparam logic [4:0] KEY_F7    = 5'd17;
  localparam logic [4:0] KEY_F8    = 5'd18;
  localparam logic [4:0] KEY_F9    = 5'd19;
  localparam logic [4:0] KEY_F10   = 5'd20;
  localparam logic [4:0] KEY_F11   = 5'd21;
  localparam logic [4:0] KEY_F12   = 5'd22;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_len;
    logic [7:0]       ctrl;
    logic [7:0]       acc;
  } tekd_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] key;
    logic [7:0] ch;
    logic [7:0] cb;
  } tekd_result_t;

  // number before '~' to key code
  function automatic logic [4:0] tilde_key(input logic [7:0] n);
    logic [4:0] k;
    unique case (n)
      8'd1:    k = KEY_HOME;
      8'd2:    k = KEY_INS;
      8'd3:    k = KEY_DEL;
      8'd4:    k = KEY_END;
      8'd5:    k = KEY_PGUP;
      8'd6:    k = KEY_PGDN;
      8'd15:   k = KEY_F5;
      8'd17:   k = KEY_F6;
      8'd18:   k = KEY_F7;
      8'd19:   k = KEY_F8;
      8'd20:   k = KEY_F9;
      8'd21:   k = KEY_F10;
      8'd23:   k = KEY_F11;
      8'd24:   k = KEY_F12;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: design/terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// turns terminal bytes into character, named key and raw key events
// ----------------------------------------------------------------------------
//  port group  dir  beat contents
//  in_*        in   in_byte, one received byte
//  out_*       out  event kind, key code, char value, control byte
//
//  one byte per cycle sustained while results are taken; a byte's event is
//  loaded into the result register from the input register, through decode.
//  sequence state is updated as a byte leaves the input register.
//  a stalled result holds the input register, which takes a new beat only
//  when it is empty or moving on; bytes with no event are held just the same.
//  synchronous active-low reset empties both registers and clears the state.
// ----------------------------------------------------------------------------
`include "terminal_escape_key_decoder_defines.svh"

module terminal_escape_key_decoder import tekd_pkg::*; #(
  parameter int unsigned MAX_SEQUENCE_BYTES = TEKD_MAX_SEQ_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [4:0] out_key_code,
  output logic [7:0] out_char_value,
  output logic [7:0] out_control_byte_out
);

  logic         in_valid_r;
  logic         in_valid_nxt;
  logic [7:0]   in_byte_r;
  tekd_state_t  state_r;
  tekd_state_t  state_nxt;
  tekd_result_t res;
  logic         res_valid;
  logic         go;

  // input register moves on when the result slot is free or draining
  assign go       = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || go;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (go) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  tekd_step #(
    .MAX_SEQ_BYTES (MAX_SEQUENCE_BYTES)
  ) u_step (
    .byte_i      (in_byte_r),
    .cur_i       (state_r),
    .nxt_o       (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tekd_out_stage u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load_i               (go && res_valid),
    .res_i                (res),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_kind       (out_event_kind),
    .out_key_code         (out_key_code),
    .out_char_value       (out_char_value),
    .out_control_byte_out (out_control_byte_out)
  );

  `TEKD_ASSERT_SAME(a_len_bound, 1'b1,
    state_r.seq_len <= SEQ_W'(MAX_SEQUENCE_BYTES), "sequence length past limit")
  `TEKD_ASSERT_SAME(a_acc_idle, state_r.seq_len == '0, state_r.acc == '0,
    "number held with no open sequence")
  `TEKD_ASSERT_NEXT(a_event_lands, go && res_valid, out_valid,
    "decoded event not in result register")
  `TEKD_ASSERT_SAME(a_char_clean, out_valid && out_event_kind == KIND_CHAR,
    out_key_code == KEY_NONE && out_control_byte_out == 8'h00,
    "plain character carries key fields")
  `TEKD_ASSERT_NEXT(a_no_overrun, in_valid_r && !go, in_valid_r && $stable(in_byte_r),
    "pending byte lost while stalled")

endmodule

FILE: design/tekd_step.sv
// ----------------------------------------------------------------------------
// tekd_step
// one byte's decode: next sequence state and optional key event
// ----------------------------------------------------------------------------
module tekd_step import tekd_pkg::*; #(
  parameter int unsigned MAX_SEQ_BYTES = TEKD_MAX_SEQ_BYTES
) (
  input  logic [7:0]   byte_i,
  input  tekd_state_t  cur_i,
  output tekd_state_t  nxt_o,
  output logic         res_valid_o,
  output tekd_result_t res_o
);

  logic [SEQ_W:0] len;
  logic [11:0]    acc_mul;
  logic [3:0]     digit;

  assign len     = {1'b0, cur_i.seq_len} + (SEQ_W+1)'(1);
  assign digit   = byte_i[3:0];
  // acc * 10 + digit, plenty of headroom for saturation
  assign acc_mul = {1'b0, cur_i.acc, 3'b000} + {3'b000, cur_i.acc, 1'b0}
                   + {8'h00, digit};

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    priority if (cur_i.seq_len == '0) begin
      if (byte_i == BYTE_ESC) begin
        nxt_o.seq_len = SEQ_W'(1);
      end else begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_CHAR;
        res_o.ch    = byte_i;
      end
    end else if (len == (SEQ_W+1)'(2)) begin
      nxt_o.seq_len = SEQ_W'(2);
      nxt_o.ctrl    = byte_i;
    end else if (len > (SEQ_W+1)'(MAX_SEQ_BYTES)) begin
      // overlong sequence is dropped silently
      nxt_o.seq_len = '0;
      nxt_o.acc     = '0;
    end else begin
      nxt_o.seq_len = len[SEQ_W-1:0];
      priority if (cur_i.ctrl == BYTE_CSI) begin
        priority if (byte_i >= BYTE_A && byte_i <= BYTE_D) begin
          nxt_o.seq_len = '0;
          nxt_o.acc     = '0;
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_KEY;
          res_o.key     = 5'(byte_i - BYTE_A) + KEY_UP;
          res_o.cb      = cur_i.ctrl;
        end else if (byte_i >= BYTE_ZERO && byte_i <= BYTE_NINE) begin
          nxt_o.acc = (acc_mul > 12'd255) ? 8'hFF : acc_mul[7:0];
        end else if (byte_i == BYTE_TILDE) begin
          nxt_o.seq_len = '0;
          nxt_o.acc     = '0;
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_KEY;
          res_o.key     = tilde_key(cur_i.acc);
          res_o.cb      = cur_i.ctrl;
        end else begin
          // anything else after csi is skipped
        end
      end else if (cur_i.ctrl == BYTE_SS3) begin
        if (byte_i >= BYTE_P && byte_i <= BYTE_S) begin
          nxt_o.seq_len = '0;
          nxt_o.acc     = '0;
          res_valid_o   = 1'b1;
          res_o.kind    = KIND_KEY;
          res_o.key     = 5'(byte_i - BYTE_P) + KEY_F1;
          res_o.cb      = cur_i.ctrl;
        end
      end else begin
        nxt_o.seq_len = '0;
        nxt_o.acc     = '0;
        res_valid_o   = 1'b1;
        res_o.kind    = KIND_RAW;
        res_o.ch      = byte_i;
        res_o.cb      = cur_i.ctrl;
      end
    end
  end

endmodule

FILE: design/tekd_out_stage.sv
// ----------------------------------------------------------------------------
// tekd_out_stage
// result register with valid/ready handshake towards the consumer
// ----------------------------------------------------------------------------
module tekd_out_stage import tekd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load_i,
  input  tekd_result_t res_i,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_event_kind,
  output logic [4:0]   out_key_code,
  output logic [7:0]   out_char_value,
  output logic [7:0]   out_control_byte_out
);

  logic         valid_r;
  logic         valid_nxt;
  tekd_result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid            = valid_r;
  assign out_event_kind       = res_r.kind;
  assign out_key_code         = res_r.key;
  assign out_char_value       = res_r.ch;
  assign out_control_byte_out = res_r.cb;

endmodule

FILE: sim/tb_terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// tb_terminal_escape_key_decoder
// byte-stream testbench: a directed set of escape sequences, then random
// well-formed and broken sequences; every event is checked against an
// in-bench decoder under varying sender and receiver idling
// ----------------------------------------------------------------------------
module tb_terminal_escape_key_decoder;
  import tekd_pkg::*;

  localparam logic [7:0] BYTE_SEMI = 8'h3B;
  localparam logic [7:0] BYTE_JUNK = 8'h5A;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 120;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_event_kind;
  logic [4:0] out_key_code;
  logic [7:0] out_char_value;
  logic [7:0] out_control_byte_out;

  terminal_escape_key_decoder u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte              (in_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_kind       (out_event_kind),
    .out_key_code         (out_key_code),
    .out_char_value       (out_char_value),
    .out_control_byte_out (out_control_byte_out)
  );

  // decoder state mirrored in the bench
  logic [SEQ_W-1:0] dec_len = '0;
  logic [7:0]       dec_ctrl = '0;
  logic [7:0]       dec_num = '0;

  logic [7:0]   tx_bytes [$];
  tekd_result_t pending_events [$];

  int unsigned tx_total = 0;
  int unsigned pressure_at = 0;
  int unsigned n_in_beats = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_chars = 0;
  int unsigned n_keys = 0;
  int unsigned n_raw = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic [22:0] key_seen = '0;

  bit           got_event;
  tekd_result_t new_event;
  tekd_result_t want;

  function automatic logic [4:0] key_for_number(input logic [7:0] n);
    case (n)
      8'd1:    return KEY_HOME;
      8'd2:    return KEY_INS;
      8'd3:    return KEY_DEL;
      8'd4:    return KEY_END;
      8'd5:    return KEY_PGUP;
      8'd6:    return KEY_PGDN;
      8'd15:   return KEY_F5;
      8'd17:   return KEY_F6;
      8'd18:   return KEY_F7;
      8'd19:   return KEY_F8;
      8'd20:   return KEY_F9;
      8'd21:   return KEY_F10;
      8'd23:   return KEY_F11;
      8'd24:   return KEY_F12;
      default: return KEY_NONE;
    endcase
  endfunction

  task automatic decode_byte(input logic [7:0] b, output bit has_ev,
                             output tekd_result_t ev);
    int unsigned v;
    has_ev = 1'b0;
    ev = '0;
    if (dec_len == 0) begin
      if (b == BYTE_ESC) begin
        dec_len = 1;
      end else begin
        has_ev = 1'b1;
        ev.kind = KIND_CHAR;
        ev.ch = b;
      end
    end else if (dec_len == 1) begin
      dec_len = 2;
      dec_ctrl = b;
    end else if (dec_len + 1 > TEKD_MAX_SEQ_BYTES) begin
      // overlong: dropped, control byte kept
      dec_len = 0;
      dec_num = 0;
    end else begin
      dec_len = dec_len + 1;
      ev.cb = dec_ctrl;
      if (dec_ctrl == BYTE_CSI) begin
        if (b >= BYTE_A && b <= BYTE_D) begin
          has_ev = 1'b1;
          ev.kind = KIND_KEY;
          ev.key = KEY_UP + 5'(b - BYTE_A);
        end else if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
          v = dec_num * 10 + (b - BYTE_ZERO);
          dec_num = (v > 255) ? 8'd255 : 8'(v);
        end else if (b == BYTE_TILDE) begin
          has_ev = 1'b1;
          ev.kind = KIND_KEY;
          ev.key = key_for_number(dec_num);
        end
      end else if (dec_ctrl == BYTE_SS3) begin
        if (b >= BYTE_P && b <= BYTE_S) begin
          has_ev = 1'b1;
          ev.kind = KIND_KEY;
          ev.key = KEY_F1 + 5'(b - BYTE_P);
        end
      end else begin
        has_ev = 1'b1;
        ev.kind = KIND_RAW;
        ev.ch = b;
      end
      if (has_ev) begin
        dec_len = 0;
        dec_num = 0;
      end
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always_comb begin
    if (n_in_beats < tx_total / 3) begin
      tx_idle_pct = 18;
      rx_idle_pct = 83;
    end else if (n_in_beats < 2 * tx_total / 3) begin
      tx_idle_pct = 83;
      rx_idle_pct = 18;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, got_event, new_event);
        if (got_event) pending_events.push_back(new_event);
        n_in_beats <= n_in_beats + 1;
      end
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected event: kind %0d key %0d char %02h ctrl %02h",
                     out_event_kind, out_key_code, out_char_value,
                     out_control_byte_out);
        end else begin
          want = pending_events.pop_front();
          case (want.kind)
            KIND_CHAR: n_chars++;
            KIND_KEY:  n_keys++;
            default:   n_raw++;
          endcase
          if (want.kind == KIND_KEY) key_seen[want.key] = 1'b1;
          if (out_event_kind !== want.kind || out_key_code !== want.key ||
              out_char_value !== want.ch || out_control_byte_out !== want.cb) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("event mismatch: exp kind %0d key %0d char %02h ctrl %02h, got kind %0d key %0d char %02h ctrl %02h",
                       want.kind, want.key, want.ch, want.cb, out_event_kind,
                       out_key_code, out_char_value, out_control_byte_out);
          end
        end
      end
      // one long hold-off so the decoder backs up and stalls its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && tx_total > 0 && n_in_beats >= pressure_at) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("terminal_escape_key_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned n;
    int unsigned v;
    tx_bytes = '{8'h00, 8'hFF,
                 BYTE_ESC, BYTE_CSI, BYTE_A,
                 BYTE_ESC, BYTE_SS3, BYTE_JUNK, BYTE_S,
                 BYTE_ESC, BYTE_CSI, BYTE_ZERO + 8'd2, BYTE_SEMI, BYTE_ZERO + 8'd4,
                 BYTE_JUNK, BYTE_TILDE,
                 BYTE_ESC, BYTE_ESC, 8'hFF,
                 BYTE_ESC, BYTE_CSI, BYTE_NINE, BYTE_NINE, BYTE_NINE, BYTE_TILDE,
                 BYTE_ESC, BYTE_SS3, BYTE_JUNK, BYTE_JUNK, BYTE_JUNK, BYTE_JUNK,
                 BYTE_JUNK, BYTE_JUNK, BYTE_JUNK, BYTE_JUNK, BYTE_A};
    while (tx_bytes.size() < 1300) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 35) begin
        tx_bytes.push_back(BYTE_ESC);
        tx_bytes.push_back(BYTE_CSI);
        tx_bytes.push_back(BYTE_A + 8'($urandom_range(0, 3)));
      end else if (r < 55) begin
        v = $urandom_range(0, 1) ? $urandom_range(0, 26) : $urandom_range(0, 999);
        tx_bytes.push_back(BYTE_ESC);
        tx_bytes.push_back(BYTE_CSI);
        case ($urandom_range(0, 3))
          0: tx_bytes.push_back(BYTE_SEMI);
          1: tx_bytes.push_back(BYTE_ZERO);
          default: ;
        endcase
        if (v >= 100) tx_bytes.push_back(BYTE_ZERO + 8'(v / 100));
        if (v >= 10) tx_bytes.push_back(BYTE_ZERO + 8'((v / 10) % 10));
        tx_bytes.push_back(BYTE_ZERO + 8'(v % 10));
        tx_bytes.push_back(BYTE_TILDE);
      end else if (r < 68) begin
        tx_bytes.push_back(BYTE_ESC);
        tx_bytes.push_back(BYTE_SS3);
        if ($urandom_range(0, 3) == 0) tx_bytes.push_back(8'($urandom_range(0, 255)));
        tx_bytes.push_back(BYTE_P + 8'($urandom_range(0, 3)));
      end else if (r < 80) begin
        tx_bytes.push_back(BYTE_ESC);
        tx_bytes.push_back(8'($urandom_range(0, 255)));
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 90) begin
        // broken or overlong sequence
        n = $urandom_range(1, 12);
        tx_bytes.push_back(BYTE_ESC);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: tx_bytes.push_back(8'($urandom_range(0, 255)));
            1: tx_bytes.push_back(BYTE_ZERO + 8'($urandom_range(0, 9)));
            2: tx_bytes.push_back(BYTE_CSI);
            default: tx_bytes.push_back(BYTE_A + 8'($urandom_range(0, 25)));
          endcase
        end
      end else begin
        tx_bytes.push_back(BYTE_ESC);
        tx_bytes.push_back(BYTE_ESC);
        tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    tx_total = tx_bytes.size();
    pressure_at = 2 * tx_total / 3 + 5;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (tx_bytes.size() != 0 || in_valid) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes; events checked: %0d characters, %0d named keys, %0d raw keys",
             n_in_beats, n_chars, n_keys, n_raw);
    $display("distinct key codes seen: %0d of 23, mismatches: %0d",
             $countones(key_seen), n_mismatch);
    if (n_mismatch == 0) begin
      $display("terminal_escape_key_decoder: match");
    end else begin
      $display("terminal_escape_key_decoder: mismatch");
    end
    $finish;
  end

endmodule

FILE: terminal_escape_key_decoder.f
+incdir+design
design/tekd_pkg.sv
design/tekd_step.sv
design/tekd_out_stage.sv
design/terminal_escape_key_decoder.sv
sim/tb_terminal_escape_key_decoder.sv
